/* sv/pbs_pkg.sv */
package pbs_pkg;

  localparam int FRAME_WIDTH     = 320;
  localparam int FRAME_HEIGHT    = 240;
  localparam int PALETTE_ENTRIES = 256;
  localparam int MAX_SCALE       = 8;
  localparam int COLOR_BITS      = 16;

  localparam int XW       = 9;
  localparam int YW       = 8;
  localparam int SCALE_W  = 4;
  localparam int IDX_W    = 8;
  localparam int ADDR_W   = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 9;
  // frame position before the frame test: origin plus scaled counter plus offset
  localparam int POS_W    = 13;
  localparam int PROD_W   = POS_W + $clog2(FRAME_WIDTH + 1);
  localparam int PAL_AW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int QDEPTH   = 4;
  localparam int QAW      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_SCALE        = 3'd4
  } cfg_reg_t;

  localparam logic ACT_PIXEL   = 1'b0;
  localparam logic ACT_PALETTE = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0]      bx;
    logic [POS_W-1:0]      by;
    logic [COLOR_BITS-1:0] color;
    logic [SCALE_W-1:0]    scale;
  } job_t;

endpackage

/* sv/pbs_front.sv */
module pbs_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [pbs_pkg::IDX_W-1:0]          in_pixel_index,
  input  logic [pbs_pkg::IDX_W-1:0]          in_palette_slot,
  input  logic [pbs_pkg::COLOR_BITS-1:0]     in_palette_color,
  output logic                               job_valid,
  input  logic                               job_ready,
  output pbs_pkg::job_t                      job
);

  logic [pbs_pkg::XW-1:0]      origin_x_r, image_width_r, col_r, col_nxt, col_inc;
  logic [pbs_pkg::YW-1:0]      origin_y_r, image_height_r, row_r, row_nxt, row_inc;
  logic [pbs_pkg::SCALE_W-1:0] scale_r, s_eff;
  logic [pbs_pkg::COLOR_BITS-1:0] pal_mem [pbs_pkg::PALETTE_ENTRIES];
  logic [pbs_pkg::COLOR_BITS-1:0] rd_data_r;
  logic                        rd_bad_r, rd_bad_nxt;
  logic                        job_v_r, job_v_nxt;
  logic [pbs_pkg::POS_W-1:0]   bx_r, by_r, bx_nxt, by_nxt;
  logic [pbs_pkg::SCALE_W-1:0] js_r;
  logic                        accept, is_pixel, opaque, pal_wr;
  logic [pbs_pkg::IDX_W-1:0]   entry;

  assign in_ready = !job_v_r || job_ready;
  assign accept   = in_valid && in_ready;
  assign is_pixel = accept && (in_action == pbs_pkg::ACT_PIXEL);
  assign opaque   = is_pixel && (in_pixel_index != '0);
  assign entry    = in_pixel_index - 1'b1;
  assign pal_wr   = accept && (in_action == pbs_pkg::ACT_PALETTE) &&
                    (32'(in_palette_slot) < 32'(pbs_pkg::PALETTE_ENTRIES));
  assign rd_bad_nxt = 32'(entry) >= 32'(pbs_pkg::PALETTE_ENTRIES);

  always_comb begin
    if (scale_r == '0) begin
      s_eff = pbs_pkg::SCALE_W'(1);
    end else if (32'(scale_r) > 32'(pbs_pkg::MAX_SCALE)) begin
      s_eff = pbs_pkg::SCALE_W'(pbs_pkg::MAX_SCALE);
    end else begin
      s_eff = scale_r;
    end
  end

  assign bx_nxt = pbs_pkg::POS_W'(origin_x_r) +
                  pbs_pkg::POS_W'(col_r) * pbs_pkg::POS_W'(s_eff);
  assign by_nxt = pbs_pkg::POS_W'(origin_y_r) +
                  pbs_pkg::POS_W'(row_r) * pbs_pkg::POS_W'(s_eff);

  // position wraps; a zero width or height compares like one
  always_comb begin
    col_inc = col_r + 1'b1;
    row_inc = row_r + 1'b1;
    col_nxt = col_inc;
    row_nxt = row_r;
    if (col_inc >= image_width_r) begin
      col_nxt = '0;
      row_nxt = (row_inc >= image_height_r) ? '0 : row_inc;
    end
  end

  always_comb begin
    job_v_nxt = job_v_r;
    if (in_ready) begin
      job_v_nxt = opaque;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      image_width_r  <= pbs_pkg::XW'(1);
      image_height_r <= pbs_pkg::YW'(1);
      scale_r        <= pbs_pkg::SCALE_W'(1);
    end else if (cfg_we) begin
      unique case (pbs_pkg::cfg_reg_t'(cfg_index))
        pbs_pkg::REG_ORIGIN_X:     origin_x_r     <= cfg_data[pbs_pkg::XW-1:0];
        pbs_pkg::REG_ORIGIN_Y:     origin_y_r     <= cfg_data[pbs_pkg::YW-1:0];
        pbs_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[pbs_pkg::XW-1:0];
        pbs_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[pbs_pkg::YW-1:0];
        pbs_pkg::REG_SCALE:        scale_r        <= cfg_data[pbs_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      job_v_r <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      if (is_pixel) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pal_wr) begin
      pal_mem[in_palette_slot[pbs_pkg::PAL_AW-1:0]] <= in_palette_color;
    end
    if (opaque) begin
      rd_data_r <= pal_mem[entry[pbs_pkg::PAL_AW-1:0]];
      rd_bad_r  <= rd_bad_nxt;
      bx_r      <= bx_nxt;
      by_r      <= by_nxt;
      js_r      <= s_eff;
    end
  end

  assign job_valid = job_v_r;
  assign job.bx    = bx_r;
  assign job.by    = by_r;
  assign job.color = rd_bad_r ? '0 : rd_data_r;
  assign job.scale = js_r;

endmodule

/* sv/pbs_queue.sv */
module pbs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  pbs_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output pbs_pkg::job_t pop_job
);

  pbs_pkg::job_t            slots_r [pbs_pkg::QDEPTH];
  logic [pbs_pkg::QAW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [pbs_pkg::QAW:0]    count_r, count_nxt;
  logic                     do_push, do_pop;

  assign push_ready = count_r != (pbs_pkg::QAW+1)'(pbs_pkg::QDEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_job    = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* sv/pbs_back.sv */
module pbs_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  pbs_pkg::job_t                  job,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pbs_pkg::ADDR_W-1:0]     out_pixel_address,
  output logic [pbs_pkg::COLOR_BITS-1:0] out_pixel_color,
  output logic                           out_last_of_run,
  output logic                           out_out_of_frame
);

  pbs_pkg::job_t               cur_r;
  logic                        cur_v_r;
  logic [pbs_pkg::SCALE_W-1:0] sx_r, sy_r, s_last;
  logic                        adv, sx_end, sy_end, last;
  logic [pbs_pkg::POS_W-1:0]   fx, fy;
  logic [pbs_pkg::PROD_W-1:0]  lin;
  logic                        off;
  logic                        out_v_r;
  logic [pbs_pkg::ADDR_W-1:0]  addr_r;
  logic [pbs_pkg::COLOR_BITS-1:0] color_r;
  logic                        last_r, off_r;

  assign s_last    = cur_r.scale - 1'b1;
  assign sx_end    = sx_r == s_last;
  assign sy_end    = sy_r == s_last;
  assign last      = sx_end && sy_end;
  assign adv       = cur_v_r && (!out_v_r || out_ready);
  assign job_ready = !cur_v_r || (adv && last);

  assign fx  = cur_r.bx + pbs_pkg::POS_W'(sx_r);
  assign fy  = cur_r.by + pbs_pkg::POS_W'(sy_r);
  assign off = (32'(fx) >= 32'(pbs_pkg::FRAME_WIDTH)) ||
               (32'(fy) >= 32'(pbs_pkg::FRAME_HEIGHT));
  assign lin = pbs_pkg::PROD_W'(fy) * pbs_pkg::PROD_W'(pbs_pkg::FRAME_WIDTH) +
               pbs_pkg::PROD_W'(fx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (job_ready) begin
        cur_v_r <= job_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // column by column, top to bottom inside a column
  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      cur_r <= job;
      sx_r  <= '0;
      sy_r  <= '0;
    end else if (adv) begin
      if (sy_end) begin
        sy_r <= '0;
        sx_r <= sx_r + 1'b1;
      end else begin
        sy_r <= sy_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      addr_r  <= off ? '0 : lin[pbs_pkg::ADDR_W-1:0];
      color_r <= cur_r.color;
      last_r  <= last;
      off_r   <= off;
    end
  end

  assign out_valid         = out_v_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_color   = color_r;
  assign out_last_of_run   = last_r;
  assign out_out_of_frame  = off_r;

endmodule

/* sv/palette_sprite_blitter_scaled.sv */
// Indexed-color sprite blitter with integer scaling.
// Input channel (in_valid/in_ready): one word per source pixel in row-major
// order (in_action 0), or a palette load (in_action 1) that writes
// in_palette_color into entry in_palette_slot. Pixel index 0 is transparent
// and gives no writes but still moves the position; index k reads entry k-1.
// Output channel (out_valid/out_ready): each opaque pixel gives scale*scale
// frame writes, column by column, the final one flagged by out_last_of_run.
// Writes outside the frame carry out_out_of_frame and address 0.
// Configuration: cfg_we with cfg_index/cfg_data, taken on the same edge;
// write only while the block is idle.
// Throughput: one input word per cycle while output writes keep up; an
// opaque pixel holds the write generator for all its scale*scale writes, one write
// per cycle, so scale 1 runs at one pixel per cycle. A 4-entry job queue
// sits between the pixel front end and the write generator.
// The first write of a pixel passes through the palette read register, the
// queue, the write generator and the output register, in that order.
// Reset: registers return to origin 0, size 1x1, scale 1, position 0 and
// the queue empty; the palette holds no defined data until loaded.
// When out_ready is low the output holds, the queue fills and in_ready
// drops once the queue and the front stage are full.
module palette_sprite_blitter_scaled (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [pbs_pkg::IDX_W-1:0]          in_pixel_index,
  input  logic [pbs_pkg::IDX_W-1:0]          in_palette_slot,
  input  logic [pbs_pkg::COLOR_BITS-1:0]     in_palette_color,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pbs_pkg::ADDR_W-1:0]         out_pixel_address,
  output logic [pbs_pkg::COLOR_BITS-1:0]     out_pixel_color,
  output logic                               out_last_of_run,
  output logic                               out_out_of_frame
);

  logic          f_valid, f_ready, b_valid, b_ready;
  pbs_pkg::job_t f_job, b_job;

  pbs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_pixel_index   (in_pixel_index),
    .in_palette_slot  (in_palette_slot),
    .in_palette_color (in_palette_color),
    .job_valid        (f_valid),
    .job_ready        (f_ready),
    .job              (f_job)
  );

  pbs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_job    (b_job)
  );

  pbs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (b_valid),
    .job_ready         (b_ready),
    .job               (b_job),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_last_of_run   (out_last_of_run),
    .out_out_of_frame  (out_out_of_frame)
  );

endmodule
